@@ sv/sled_pkg.sv @@
// Shared constants, tables and helper functions of the status LED animation engine.
`default_nettype none
package sled_pkg;
	localparam int MAX_LEDS    = 8;
	localparam int UPDATE_RATE = 50;
	localparam int RESULT_LIMIT = 8;
	localparam int LED_LIMIT   = (MAX_LEDS < RESULT_LIMIT) ? MAX_LEDS : RESULT_LIMIT;
	localparam int LED_AW      = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;

	localparam int SLOW_PERIOD = UPDATE_RATE / 1;
	localparam int FAST_PERIOD = UPDATE_RATE / 4;
	localparam int PULSE_PERIOD = UPDATE_RATE * 2;
	localparam int HALF_PERIOD = PULSE_PERIOD / 2;
	localparam int SLOW_W  = $clog2(SLOW_PERIOD);
	localparam int FAST_W  = $clog2(FAST_PERIOD);
	localparam int PULSE_W = $clog2(PULSE_PERIOD);

	localparam logic [1:0] OP_TICK   = 2'd0;
	localparam logic [1:0] OP_STATUS = 2'd1;
	localparam logic [1:0] OP_CUSTOM = 2'd2;
	localparam logic [1:0] OP_ENABLE = 2'd3;

	localparam logic [2:0] MODE_SOLID = 3'd0;
	localparam logic [2:0] MODE_SLOW  = 3'd1;
	localparam logic [2:0] MODE_FAST  = 3'd2;
	localparam logic [2:0] MODE_PULSE = 3'd3;
	localparam logic [2:0] MODE_FLASH = 3'd4;

	localparam logic [23:0] COLOUR_WHITE = 24'hFFFFFF;
	localparam logic [23:0] COLOUR_OFF   = 24'h000000;
	localparam logic [3:0]  LEVEL_COUNT  = 4'd10;

	localparam logic [23:0] LEVEL_COLOUR [10] = '{
		24'h000000, 24'h00FF00, 24'hFFFF00, 24'hFF0000, 24'hFF0000,
		24'h0000FF, 24'h00FFFF, 24'hFF00FF, 24'hFFFFFF, 24'hFFFFFF
	};
	localparam logic [2:0] LEVEL_MODE [10] = '{
		MODE_SOLID, MODE_SOLID, MODE_SLOW, MODE_FAST, MODE_SOLID,
		MODE_SOLID, MODE_FAST, MODE_PULSE, MODE_SOLID, MODE_PULSE
	};

	typedef struct packed {
		logic        wr_en;
		logic [LED_AW-1:0] wr_addr;
		logic [23:0] wr_colour;
		logic [2:0]  wr_mode;
	} store_wr_t;

	function automatic logic [7:0] pulse_level(input logic [PULSE_W-1:0] q);
		int qi;
		int t;
		qi = int'(q);
		if (qi < HALF_PERIOD) begin
			t = qi * 255 / HALF_PERIOD;
		end else begin
			t = 255 - (qi - HALF_PERIOD) * 255 / HALF_PERIOD;
		end
		return 8'(50 + t * 205 / 255);
	endfunction
endpackage
`default_nettype wire

@@ sv/sled_intf.sv @@
// Handshake channel interfaces for items, results and the configuration write.
`default_nettype none
interface sled_item_if;
	logic        valid;
	logic        ready;
	logic [1:0]  op;
	logic [3:0]  led_index;
	logic [3:0]  status_level;
	logic [23:0] custom_rgb;
	logic [2:0]  animation;
	logic        enable_flag;
	modport source(output valid, op, led_index, status_level, custom_rgb, animation,
		enable_flag, input ready);
	modport sink(input valid, op, led_index, status_level, custom_rgb, animation,
		enable_flag, output ready);
endinterface

interface sled_result_if;
	logic       valid;
	logic       ready;
	logic [2:0] out_index;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;
	logic       last_led;
	modport source(output valid, out_index, red, green, blue, last_led, input ready);
	modport sink(input valid, out_index, red, green, blue, last_led, output ready);
endinterface

interface sled_cfg_if;
	logic       valid;
	logic       ready;
	logic [3:0] active_leds;
	modport source(output valid, active_leds, input ready);
	modport sink(input valid, active_leds, output ready);
endinterface
`default_nettype wire

@@ sv/status_led_animation_engine_top.sv @@
// Top level of the status LED animation engine: sequencer, phase counters and output register.
// A tick while enabled, or a disable, walks the LEDs in use one after another through a single
// shared 8x8 scaling multiplier: each LED passes through store read, level select, then red,
// green and blue through the multiplier, then the output load, which waits while the result
// side stalls. Items are not taken while a frame is being walked. The animation phase is held
// as three counters modulo the slow blink, fast blink and pulse periods, advanced per tick
// while enabled.
`default_nettype none
module status_led_animation_engine_top (
	input  wire logic  clk,
	input  wire logic  arst_n,
	sled_item_if.sink  item,
	sled_result_if.source result,
	sled_cfg_if.sink   cfg
);
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_RD   = 3'd1;
	localparam logic [2:0] ST_FAC  = 3'd2;
	localparam logic [2:0] ST_MR   = 3'd3;
	localparam logic [2:0] ST_MG   = 3'd4;
	localparam logic [2:0] ST_MB   = 3'd5;
	localparam logic [2:0] ST_EM   = 3'd6;

	logic [2:0] state_q;
	logic [3:0] active_leds_q;
	logic       en_q;
	logic       blank_q;
	logic [2:0] idx_q;
	logic [sled_pkg::SLOW_W-1:0]  slow_q;
	logic [sled_pkg::FAST_W-1:0]  fast_q;
	logic [sled_pkg::PULSE_W-1:0] pulse_q;
	logic [7:0]  factor_q;
	logic [23:0] colour_q;
	logic [7:0]  red_q;
	logic [7:0]  green_q;
	logic        out_valid_q;
	logic [2:0]  out_index_q;
	logic [7:0]  out_red_q;
	logic [7:0]  out_green_q;
	logic [7:0]  out_blue_q;
	logic        out_last_q;

	logic [3:0]  n_use;
	logic        item_acc;
	logic        addr_ok;
	logic        start_frame;
	logic        is_last;
	logic        out_free;
	logic [23:0] rd_colour;
	logic [2:0]  rd_mode;
	logic [7:0]  chan;
	logic [7:0]  scaled_q;
	logic [7:0]  factor_d;
	logic [7:0]  pulse_tab [sled_pkg::PULSE_PERIOD];
	sled_pkg::store_wr_t wr;

	for (genvar g = 0; g < sled_pkg::PULSE_PERIOD; g++) begin : g_pulse
		localparam logic [7:0] PULSE_LVL = sled_pkg::pulse_level(sled_pkg::PULSE_W'(g));
		assign pulse_tab[g] = PULSE_LVL;
	end

	assign n_use = (active_leds_q > 4'(sled_pkg::LED_LIMIT)) ? 4'(sled_pkg::LED_LIMIT)
		: active_leds_q;
	assign item.ready = (state_q == ST_IDLE);
	assign cfg.ready  = 1'b1;
	assign item_acc   = item.valid && item.ready;
	assign addr_ok    = item.led_index < n_use;
	assign is_last    = (4'(idx_q) + 4'd1) == n_use;
	assign out_free   = !out_valid_q || result.ready;

	always_comb begin
		start_frame = 1'b0;
		if (item_acc && n_use != 4'd0) begin
			unique case (item.op)
				sled_pkg::OP_TICK:   start_frame = en_q;
				sled_pkg::OP_ENABLE: start_frame = !item.enable_flag;
				default:             start_frame = 1'b0;
			endcase
		end
	end

	always_comb begin
		wr.wr_en     = 1'b0;
		wr.wr_addr   = sled_pkg::LED_AW'(item.led_index);
		wr.wr_colour = item.custom_rgb;
		wr.wr_mode   = item.animation;
		if (item_acc && addr_ok) begin
			unique case (item.op)
				sled_pkg::OP_STATUS: begin
					wr.wr_en = 1'b1;
					if (item.status_level < sled_pkg::LEVEL_COUNT) begin
						wr.wr_colour = sled_pkg::LEVEL_COLOUR[item.status_level];
						wr.wr_mode   = sled_pkg::LEVEL_MODE[item.status_level];
					end else begin
						wr.wr_colour = sled_pkg::COLOUR_OFF;
						wr.wr_mode   = sled_pkg::MODE_SOLID;
					end
				end
				sled_pkg::OP_CUSTOM: wr.wr_en = 1'b1;
				default:             wr.wr_en = 1'b0;
			endcase
		end
	end

	sled_store u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (wr),
		.rd_addr  (sled_pkg::LED_AW'(idx_q)),
		.rd_colour(rd_colour),
		.rd_mode  (rd_mode)
	);

	always_comb begin
		if (blank_q) begin
			factor_d = 8'd0;
		end else begin
			unique case (rd_mode)
				sled_pkg::MODE_SLOW:
					factor_d = (slow_q < sled_pkg::SLOW_W'(sled_pkg::SLOW_PERIOD / 2))
						? 8'd255 : 8'd0;
				sled_pkg::MODE_FAST:
					factor_d = (fast_q < sled_pkg::FAST_W'(sled_pkg::FAST_PERIOD / 2))
						? 8'd255 : 8'd0;
				sled_pkg::MODE_PULSE: factor_d = pulse_tab[pulse_q];
				sled_pkg::MODE_FLASH: factor_d = 8'd0;
				default:              factor_d = 8'd255;
			endcase
		end
	end

	always_comb begin
		unique case (state_q)
			ST_MR:   chan = colour_q[23:16];
			ST_MG:   chan = colour_q[15:8];
			default: chan = colour_q[7:0];
		endcase
	end

	sled_scale u_scale (
		.clk     (clk),
		.chan    (chan),
		.level   (factor_q),
		.scaled_q(scaled_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_leds_q <= 4'd8;
		end else if (cfg.valid && cfg.ready) begin
			active_leds_q <= cfg.active_leds;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			en_q    <= 1'b1;
			blank_q <= 1'b0;
			idx_q   <= '0;
			slow_q  <= '0;
			fast_q  <= '0;
			pulse_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_EM && out_free) begin
				out_valid_q <= 1'b1;
			end else if (result.valid && result.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (item_acc && item.op == sled_pkg::OP_TICK && en_q) begin
						slow_q  <= (slow_q == sled_pkg::SLOW_W'(sled_pkg::SLOW_PERIOD - 1))
							? '0 : slow_q + 1'b1;
						fast_q  <= (fast_q == sled_pkg::FAST_W'(sled_pkg::FAST_PERIOD - 1))
							? '0 : fast_q + 1'b1;
						pulse_q <= (pulse_q == sled_pkg::PULSE_W'(sled_pkg::PULSE_PERIOD - 1))
							? '0 : pulse_q + 1'b1;
					end
					if (item_acc && item.op == sled_pkg::OP_ENABLE) begin
						en_q <= item.enable_flag;
					end
					if (start_frame) begin
						blank_q <= (item.op == sled_pkg::OP_ENABLE);
						idx_q   <= '0;
						state_q <= ST_RD;
					end
				end
				ST_RD:  state_q <= ST_FAC;
				ST_FAC: state_q <= ST_MR;
				ST_MR:  state_q <= ST_MG;
				ST_MG:  state_q <= ST_MB;
				ST_MB:  state_q <= ST_EM;
				ST_EM: begin
					if (out_free) begin
						if (is_last) begin
							state_q <= ST_IDLE;
						end else begin
							idx_q   <= idx_q + 3'd1;
							state_q <= ST_RD;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FAC) begin
			factor_q <= factor_d;
			colour_q <= rd_colour;
		end
		if (state_q == ST_MG) begin
			red_q <= scaled_q;
		end
		if (state_q == ST_MB) begin
			green_q <= scaled_q;
		end
		if (state_q == ST_EM && out_free) begin
			out_index_q <= idx_q;
			out_red_q   <= red_q;
			out_green_q <= green_q;
			out_blue_q  <= scaled_q;
			out_last_q  <= is_last;
		end
	end

	assign result.valid     = out_valid_q;
	assign result.out_index = out_index_q;
	assign result.red       = out_red_q;
	assign result.green     = out_green_q;
	assign result.blue      = out_blue_q;
	assign result.last_led  = out_last_q;
endmodule
`default_nettype wire

@@ sv/sled_store.sv @@
// Per-LED colour and mode registers with one write port and a registered read port.
`default_nettype none
module sled_store (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire sled_pkg::store_wr_t       wr,
	input  wire logic [sled_pkg::LED_AW-1:0] rd_addr,
	output logic [23:0]                    rd_colour,
	output logic [2:0]                     rd_mode
);
	logic [23:0] colour_q [sled_pkg::MAX_LEDS];
	logic [2:0]  mode_q   [sled_pkg::MAX_LEDS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < sled_pkg::MAX_LEDS; i++) begin
				colour_q[i] <= sled_pkg::COLOUR_WHITE;
				mode_q[i]   <= sled_pkg::MODE_PULSE;
			end
		end else if (wr.wr_en) begin
			colour_q[wr.wr_addr] <= wr.wr_colour;
			mode_q[wr.wr_addr]   <= wr.wr_mode;
		end
	end

	always_ff @(posedge clk) begin
		rd_colour <= colour_q[rd_addr];
		rd_mode   <= mode_q[rd_addr];
	end
endmodule
`default_nettype wire

@@ sv/sled_scale.sv @@
// Shared 8x8 scaling unit: registered channel times level divided by 255.
`default_nettype none
module sled_scale (
	input  wire logic       clk,
	input  wire logic [7:0] chan,
	input  wire logic [7:0] level,
	output logic [7:0]      scaled_q
);
	logic [15:0] prod;
	logic [16:0] adj;

	assign prod = 16'(chan) * 16'(level);
	assign adj  = {1'b0, prod} + 17'(prod[15:8]) + 17'd1;

	always_ff @(posedge clk) begin
		scaled_q <= adj[15:8];
	end
endmodule
`default_nettype wire

@@ sv/sled_checker.sv @@
// Port-level checks of the status LED animation engine and their binding to the top level.
`default_nettype none
module sled_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       item_valid,
	input wire logic       item_ready,
	input wire logic       result_valid,
	input wire logic       result_ready,
	input wire logic [2:0] out_index,
	input wire logic [7:0] red,
	input wire logic [7:0] green,
	input wire logic [7:0] blue,
	input wire logic       last_led
);
	logic res_acc;
	assign res_acc = result_valid && result_ready;

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(out_index) && $stable(red)
			&& $stable(green) && $stable(blue) && $stable(last_led))
		else $error("stalled result transaction changed");

	a_busy_mid_frame: assert property (@(posedge clk) disable iff (!arst_n)
		res_acc && !last_led |-> !item_ready && !(item_valid && item_ready))
		else $error("item taken while a frame is still being emitted");

	a_top_index_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && out_index == 3'd7 |-> last_led)
		else $error("LED seven not marked as last");
endmodule

bind status_led_animation_engine_top sled_checker u_sled_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.item_valid  (item.valid),
	.item_ready  (item.ready),
	.result_valid(result.valid),
	.result_ready(result.ready),
	.out_index   (result.out_index),
	.red         (result.red),
	.green       (result.green),
	.blue        (result.blue),
	.last_led    (result.last_led)
);
`default_nettype wire
